// File: src/l3d_pkg.sv
// ----------------------------------------------------------------------------
// l3d_pkg
// Shared types and constants of the 3D LUT interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package l3d_pkg;

  localparam int MaxLutSizeDefault    = 33;
  localparam int ComponentBitsDefault = 16;
  localparam int CfgDataBits          = 6;
  localparam int CfgIndexBits         = 1;
  localparam int IndexBits            = 16;

  localparam logic [CfgIndexBits-1:0] REG_LUT_SIZE    = 1'b0;
  localparam logic [CfgIndexBits-1:0] REG_INTERP_MODE = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SPLIT,
    BK_READ,
    BK_BLEND
  } bk_state_t;

endpackage
`default_nettype wire

// File: src/lut3d_color_interpolator.sv
// ----------------------------------------------------------------------------
// lut3d_color_interpolator
// 3D colour LUT with trilinear or nearest-node lookup.
// ----------------------------------------------------------------------------
// A load item writes one table entry in the cycle it is accepted and gives no
// result. A pixel item goes to a two-entry queue; the pixel engine reads its
// corners from the single table port one per cycle. Once it leaves the queue a
// trilinear pixel goes through a take step, three split steps, a table setup
// step, eight reads and the last capture, and seven lerps; a nearest pixel
// reads a single corner; the result strobe follows in the next cycle.
// busy is high while the queue is full, and for a load while any pixel is
// queued or in the engine, so loads never overtake pixels. Each result appears
// for one cycle with done high; the receiver cannot stall it. No clearing
// pass: unwritten entries are undefined.
`default_nettype none
module lut3d_color_interpolator #(
  parameter int MaxLutSize    = l3d_pkg::MaxLutSizeDefault,
  parameter int ComponentBits = l3d_pkg::ComponentBitsDefault
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [l3d_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [l3d_pkg::CfgDataBits-1:0]  cfg_data,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      command,
  input  wire logic [l3d_pkg::IndexBits-1:0]    entry_index,
  input  wire logic [ComponentBits-1:0]  in_r,
  input  wire logic [ComponentBits-1:0]  in_g,
  input  wire logic [ComponentBits-1:0]  in_b,
  output logic                           done,
  output logic      [ComponentBits-1:0]  out_r,
  output logic      [ComponentBits-1:0]  out_g,
  output logic      [ComponentBits-1:0]  out_b
);
  import l3d_pkg::*;

  localparam int Depth    = MaxLutSize*MaxLutSize*MaxLutSize;
  localparam int AddrBits = $clog2(Depth);
  localparam int Wb       = 3*ComponentBits;

  logic accept, load_we, pixel_push, q_full, q_ne, q_pop, engine_idle, nearest;
  logic [AddrBits-1:0] load_addr, rd_addr;
  logic [Wb-1:0] q_head, rd_data;
  logic [CfgDataBits-1:0] size_eff;

  // loads wait until every earlier pixel has read the table
  assign busy   = q_full || (command == CMD_LOAD && (q_ne || !engine_idle));
  assign accept = start && !busy;

  l3d_front #(.MaxLutSize(MaxLutSize), .ComponentBits(ComponentBits)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .accept, .command, .entry_index,
    .load_we, .load_addr, .pixel_push, .size_eff, .nearest
  );

  l3d_queue #(.Width(Wb)) u_queue (
    .clk, .rst, .push(pixel_push), .push_data({in_b, in_g, in_r}), .pop(q_pop),
    .full(q_full), .not_empty(q_ne), .head(q_head)
  );

  l3d_ram #(.Width(Wb), .Depth(Depth)) u_ram (
    .clk, .we(load_we), .addr(load_we ? load_addr : rd_addr),
    .wdata({in_b, in_g, in_r}), .rdata(rd_data)
  );

  l3d_back #(.MaxLutSize(MaxLutSize), .ComponentBits(ComponentBits)) u_back (
    .clk, .rst, .item_valid(q_ne), .item_data(q_head), .size_eff, .nearest,
    .item_pop(q_pop), .idle(engine_idle), .rd_addr, .rd_data,
    .res_valid(done), .res_r(out_r), .res_g(out_g), .res_b(out_b)
  );
endmodule
`default_nettype wire

// File: src/l3d_ram.sv
// ----------------------------------------------------------------------------
// l3d_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module l3d_ram #(
  parameter int Width = 48,
  parameter int Depth = 35937
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: src/l3d_queue.sv
// ----------------------------------------------------------------------------
// l3d_queue
// Small queue between the front and back parts; holds pixel items.
// ----------------------------------------------------------------------------
`default_nettype none
module l3d_queue #(
  parameter int Width = 48
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [Width-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic      [Width-1:0] head
);
  logic [Width-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];

  // two-entry ring
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end
endmodule
`default_nettype wire

// File: src/l3d_back.sv
// ----------------------------------------------------------------------------
// l3d_back
// Pixel engine: per-axis split, eight corner reads, seven lerps per channel; one read in nearest mode.
// ----------------------------------------------------------------------------
`default_nettype none
module l3d_back #(
  parameter int MaxLutSize    = l3d_pkg::MaxLutSizeDefault,
  parameter int ComponentBits = l3d_pkg::ComponentBitsDefault,
  parameter int AddrBits      = $clog2(MaxLutSize*MaxLutSize*MaxLutSize)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire logic [3*ComponentBits-1:0] item_data,
  input  wire logic [l3d_pkg::CfgDataBits-1:0] size_eff,
  input  wire logic                       nearest,
  output logic                            item_pop,
  output logic                            idle,
  output logic      [AddrBits-1:0]        rd_addr,
  input  wire logic [3*ComponentBits-1:0] rd_data,
  output logic                            res_valid,
  output logic      [ComponentBits-1:0]   res_r,
  output logic      [ComponentBits-1:0]   res_g,
  output logic      [ComponentBits-1:0]   res_b
);
  import l3d_pkg::*;

  localparam int Cb = ComponentBits;
  localparam logic [Cb-1:0] Full = {Cb{1'b1}};
  localparam logic [Cb-1:0] Half = {1'b0, {(Cb-1){1'b1}}};
  localparam int Pb = Cb + CfgDataBits;
  localparam int Lb = 2*Cb + 1;

  bk_state_t state, state_next;
  logic [1:0]  axis;
  logic [3:0]  step;
  logic [Cb-1:0] coord [3];
  logic [CfgDataBits-1:0] base [3];
  logic [Cb-1:0] frac [3];
  logic [3*Cb-1:0] corner [8];
  logic [2:0]  lerp_idx;
  logic [Cb-1:0] lv [3][7];

  // per-axis split: p = c*(n-1), divide by full scale via p = hi*2^Cb + lo
  logic [Cb-1:0] cur_c;
  logic [Pb-1:0] prod;
  logic [Pb:0]   pr;
  logic [Pb-Cb:0] q0;
  logic [Cb:0]   r0;
  logic [CfgDataBits-1:0] qv;
  logic [Cb-1:0] rv;
  logic [CfgDataBits-1:0] nm1;

  assign cur_c = coord[axis];
  assign nm1   = size_eff - 1'b1;
  assign prod  = cur_c * nm1;
  // nearest adds (F-1)/2 before dividing
  assign pr    = {1'b0, prod} + (nearest ? {{(Pb-Cb+1){1'b0}}, Half} : '0);
  // division by 2^Cb - 1: q = hi, r = lo + hi, fix up once
  always_comb begin
    q0 = pr[Pb:Cb];
    r0 = {1'b0, pr[Cb-1:0]} + {{(2*Cb-Pb){1'b0}}, q0};
    if (r0 >= {1'b0, Full}) begin
      qv = CfgDataBits'(q0 + 1'b1);
      rv = Cb'(r0 - {1'b0, Full});
    end else begin
      qv = CfgDataBits'(q0);
      rv = r0[Cb-1:0];
    end
  end

  // corner address: ri + n*(gi + n*bi)
  logic [2:0] corner_sel;
  logic [CfgDataBits-1:0] ci [3];
  assign corner_sel = step[2:0];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ci[a] = nearest ? base[a] : CfgDataBits'(base[a] + {{(CfgDataBits-1){1'b0}},
                                                           corner_sel[a]});
    end
  end
  logic [AddrBits-1:0] gb_r;
  logic [2:0] rd_tag;
  logic       rd_pend;
  logic       rd_en;

  // g,b part of the address for the next corner
  logic [2:0] nsel;
  logic [AddrBits-1:0] gb_next;
  logic [CfgDataBits-1:0] ng, nb;
  assign nsel = 3'(step + 1'b1);
  assign ng = nearest ? base[1] : CfgDataBits'(base[1] + {{(CfgDataBits-1){1'b0}}, nsel[1]});
  assign nb = nearest ? base[2] : CfgDataBits'(base[2] + {{(CfgDataBits-1){1'b0}}, nsel[2]});
  assign gb_next  = AddrBits'(ng) + AddrBits'(size_eff) * AddrBits'(nb);

  // lerp unit, one channel-lerp per pass over three channels
  logic [Cb-1:0] la [3];
  logic [Cb-1:0] lb [3];
  logic [Cb-1:0] lt;
  logic [Cb-1:0] lres [3];
  always_comb begin
    unique case (lerp_idx)
      3'd0, 3'd1, 3'd2, 3'd3: lt = frac[2];
      3'd4, 3'd5:             lt = frac[1];
      default:                lt = frac[0];
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      unique case (lerp_idx)
        // pairs along b; lerp_idx bit 1 picks r, bit 0 picks g
        3'd0, 3'd1, 3'd2, 3'd3: begin
          la[ch] = corner[{1'b0, lerp_idx[0], lerp_idx[1]}][ch*Cb +: Cb];
          lb[ch] = corner[{1'b1, lerp_idx[0], lerp_idx[1]}][ch*Cb +: Cb];
        end
        3'd4: begin la[ch] = lv[ch][0]; lb[ch] = lv[ch][1]; end
        3'd5: begin la[ch] = lv[ch][2]; lb[ch] = lv[ch][3]; end
        default: begin la[ch] = lv[ch][4]; lb[ch] = lv[ch][5]; end
      endcase
    end
  end
  logic [Lb-1:0] ls [3];
  logic [Lb-Cb-1:0] lq0 [3];
  logic [Cb:0] lr0 [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      ls[ch]  = Lb'(la[ch] * (Full - lt)) + Lb'(lb[ch] * lt) + Lb'(Half);
      lq0[ch] = ls[ch][Lb-1:Cb];
      lr0[ch] = {1'b0, ls[ch][Cb-1:0]} + (Cb+1)'(lq0[ch]);
      lres[ch] = (lr0[ch] >= {1'b0, Full}) ? Cb'(lq0[ch] + 1'b1) : Cb'(lq0[ch]);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencing
  always_comb begin
    state_next = state;
    item_pop   = 1'b0;
    unique case (state)
      BK_IDLE:  if (item_valid) begin
        state_next = BK_SPLIT;
        item_pop   = 1'b1;
      end
      BK_SPLIT: if (axis == 2'd2) state_next = BK_READ;
      BK_READ:  if (rd_pend && (rd_tag == 3'd7 || nearest)) begin
        state_next = nearest ? BK_IDLE : BK_BLEND;
      end
      BK_BLEND: if (lerp_idx == 3'd6) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  assign idle    = (state == BK_IDLE);
  assign rd_en   = (state == BK_READ) && (step < 4'd8) && !(nearest && step != 4'd0);
  // g,b part of the read address, g+n*b, precomputed in a register
  assign rd_addr = AddrBits'(ci[0]) + AddrBits'(size_eff) * gb_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      rd_pend   <= rd_en;
      if (state == BK_READ && rd_pend && nearest) res_valid <= 1'b1;
      if (state == BK_BLEND && lerp_idx == 3'd6) res_valid <= 1'b1;
    end
    unique case (state)
      BK_IDLE: begin
        axis <= 2'd0;
        step <= 4'd0;
        lerp_idx <= 3'd0;
        for (int a = 0; a < 3; a++) coord[a] <= item_data[a*Cb +: Cb];
      end
      BK_SPLIT: begin
        if (!nearest && qv >= nm1) begin
          base[axis] <= CfgDataBits'(size_eff - 2'd2);
          frac[axis] <= Full;
        end else begin
          base[axis] <= qv;
          frac[axis] <= rv;
        end
        axis <= axis + 1'b1;
        step <= 4'd15;
      end
      BK_READ: begin
        // g,b part of the address is computed for the next corner and registered
        if (step == 4'd15) begin
          step <= 4'd0;
        end else if (rd_en) begin
          step <= step + 1'b1;
        end
        gb_r   <= gb_next;
        rd_tag <= corner_sel;
        if (rd_pend) corner[rd_tag] <= rd_data;
      end
      BK_BLEND: begin
        lerp_idx <= lerp_idx + 1'b1;
        for (int ch = 0; ch < 3; ch++) lv[ch][lerp_idx] <= lres[ch];
      end
      default: ;
    endcase
    if (state == BK_READ && rd_pend && nearest) begin
      res_r <= rd_data[0 +: Cb];
      res_g <= rd_data[Cb +: Cb];
      res_b <= rd_data[2*Cb +: Cb];
    end
    if (state == BK_BLEND && lerp_idx == 3'd6) begin
      res_r <= lres[0];
      res_g <= lres[1];
      res_b <= lres[2];
    end
  end
endmodule
`default_nettype wire

// File: src/l3d_front.sv
// ----------------------------------------------------------------------------
// l3d_front
// Command front: holds the registers, performs loads, queues pixel items.
// ----------------------------------------------------------------------------
`default_nettype none
module l3d_front #(
  parameter int MaxLutSize    = l3d_pkg::MaxLutSizeDefault,
  parameter int ComponentBits = l3d_pkg::ComponentBitsDefault,
  parameter int AddrBits      = $clog2(MaxLutSize*MaxLutSize*MaxLutSize)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [l3d_pkg::CfgIndexBits-1:0] cfg_index,
  input  wire logic [l3d_pkg::CfgDataBits-1:0]  cfg_data,
  input  wire logic                       accept,
  input  wire logic                       command,
  input  wire logic [l3d_pkg::IndexBits-1:0]    entry_index,
  output logic                            load_we,
  output logic      [AddrBits-1:0]        load_addr,
  output logic                            pixel_push,
  output logic      [l3d_pkg::CfgDataBits-1:0]  size_eff,
  output logic                            nearest
);
  import l3d_pkg::*;

  logic [CfgDataBits-1:0] lut_size;
  logic [3*CfgDataBits:0] cube;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lut_size <= CfgDataBits'(MaxLutSize);
      nearest  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LUT_SIZE:    lut_size <= cfg_data;
        REG_INTERP_MODE: nearest  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturate size to the supported range
  always_comb begin
    if (lut_size < 6'd2) size_eff = 6'd2;
    else if (32'(lut_size) > MaxLutSize) size_eff = CfgDataBits'(MaxLutSize);
    else size_eff = lut_size;
  end

  assign cube       = (3*CfgDataBits+1)'(size_eff) * size_eff * size_eff;
  assign load_we    = accept && command == CMD_LOAD &&
                      {{(3*CfgDataBits+1-IndexBits){1'b0}}, entry_index} < cube;
  assign load_addr  = AddrBits'(entry_index);
  assign pixel_push = accept && command == CMD_PIXEL;
endmodule
`default_nettype wire
